FILE: hdl/fir_filter_power_of_two_coefficients_assert.svh
// assertion helpers for the power-of-two fir block
`ifndef FIR_FILTER_POWER_OF_TWO_COEFFICIENTS_ASSERT_SVH
`define FIR_FILTER_POWER_OF_TWO_COEFFICIENTS_ASSERT_SVH

`ifndef SYNTHESIS

`define FIR_P2C_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FIR_P2C_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FIR_P2C_ASSERT_IMPLY(label, ante, cons, msg)

`define FIR_P2C_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hdl/fir_p2c_pkg.sv
package fir_p2c_pkg;

    localparam int NUM_COEFFS    = 512;
    localparam int NUM_GROUPS    = 16;
    localparam int HISTORY_DEPTH = 256;

    localparam int COEF_AW  = $clog2(NUM_COEFFS);
    localparam int GROUP_AW = $clog2(NUM_GROUPS);
    localparam int HIST_AW  = $clog2(HISTORY_DEPTH);
    localparam int CCNT_W   = $clog2(NUM_COEFFS + 1);

    localparam int MODE_W     = 2;
    localparam int INDEX_W    = 9;
    localparam int SIZE_W     = 10;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 9;
    localparam int DELAY_W    = 8;
    localparam int COEF_SIGN  = 8;
    localparam int ACC_W      = 64;
    localparam int DATA_POS   = 40;
    localparam int OUT_POS    = 24;
    localparam int OUT_W      = 40;
    localparam int IN_TDATA_W = 40;

    localparam int END_SUM_W = ((CCNT_W > SIZE_W) ? CCNT_W : SIZE_W) + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_GROUP = 2'd0,
        MODE_LOAD_COEF  = 2'd1,
        MODE_FILTER     = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // one operation issued into the datapath pipeline per cycle
    typedef struct packed {
        logic               valid;
        logic               term;
        logic               last;
        logic [COEF_AW-1:0] addr;
    } issue_t;

    typedef struct packed {
        logic acc_clear;
        logic hist_we;
        logic ptr_advance;
        logic coef_we;
    } dp_ctl_t;

    // end of the next group, clamped to the coefficient table
    function automatic logic [CCNT_W-1:0] clamp_end(
        input logic [CCNT_W-1:0] base,
        input logic [SIZE_W-1:0] size
    );
        logic [END_SUM_W-1:0] sum;
        begin
            sum = END_SUM_W'(base) + END_SUM_W'(size);
            if (sum > END_SUM_W'(NUM_COEFFS))
            begin
                clamp_end = CCNT_W'(NUM_COEFFS);
            end
            else
            begin
                clamp_end = sum[CCNT_W-1:0];
            end
        end
    endfunction

endpackage

FILE: hdl/fir_p2c_datapath.sv
module fir_p2c_datapath
    import fir_p2c_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_ctl_t                    ctl,
    input  logic [COEF_AW-1:0]         wr_addr,
    input  logic [COEF_W-1:0]          wr_coef,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  issue_t                     issue,
    output logic                       busy,
    output logic [OUT_W-1:0]           result
);

    logic [COEF_W-1:0]   coef_mem [NUM_COEFFS];
    logic [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];
    logic                hist_valid_reg [HISTORY_DEPTH];

    logic [HIST_AW-1:0]  ptr_reg;
    logic [COEF_W-1:0]   coef_rd_reg;
    logic [SAMPLE_W-1:0] hist_rd_reg;
    logic                hist_ok_reg;
    logic                b_neg_reg;
    logic                a_valid_reg;
    logic                a_term_reg;
    logic                a_last_reg;
    logic                b_valid_reg;
    logic                b_term_reg;
    logic                b_last_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    acc_next;

    logic [DELAY_W-1:0]  delay;
    logic                delay_ok;
    logic [HIST_AW-1:0]  hist_addr;
    logic [SAMPLE_W-1:0] x;
    logic [ACC_W-1:0]    term;
    logic [ACC_W-1:0]    sum;

    assign delay     = coef_rd_reg[DELAY_W-1:0];
    assign delay_ok  = (DELAY_W + 1)'(delay) < (DELAY_W + 1)'(HISTORY_DEPTH);
    assign hist_addr = ptr_reg - HIST_AW'(delay);

    always_ff @(posedge clk)
    begin
        if (ctl.coef_we)
        begin
            coef_mem[wr_addr] <= wr_coef;
        end
        coef_rd_reg <= coef_mem[issue.addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.hist_we)
        begin
            hist_mem[ptr_reg] <= sample;
        end
        hist_rd_reg <= hist_mem[hist_addr];
        hist_ok_reg <= hist_valid_reg[hist_addr] && delay_ok;
        b_neg_reg   <= coef_rd_reg[COEF_SIGN];
    end

    // unwritten history slots read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HISTORY_DEPTH; k++)
            begin
                hist_valid_reg[k] <= 1'b0;
            end
        end
        else if (ctl.hist_we)
        begin
            hist_valid_reg[ptr_reg] <= 1'b1;
        end
    end

    always_comb
    begin
        x    = hist_ok_reg ? hist_rd_reg : '0;
        term = {{(ACC_W - DATA_POS - SAMPLE_W){x[SAMPLE_W-1]}}, x, {DATA_POS{1'b0}}};
        sum  = b_neg_reg ? (acc_reg - term) : (acc_reg + term);
        acc_next = b_term_reg ? sum : acc_reg;
        // close of a group: arithmetic shift right by one
        if (b_last_reg)
        begin
            acc_next = {acc_next[ACC_W-1], acc_next[ACC_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            a_valid_reg <= 1'b0;
            a_term_reg  <= 1'b0;
            a_last_reg  <= 1'b0;
            b_valid_reg <= 1'b0;
            b_term_reg  <= 1'b0;
            b_last_reg  <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            if (ctl.ptr_advance)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            a_valid_reg <= issue.valid;
            a_term_reg  <= issue.valid & issue.term;
            a_last_reg  <= issue.valid & issue.last;
            b_valid_reg <= a_valid_reg;
            b_term_reg  <= a_term_reg;
            b_last_reg  <= a_last_reg;
            if (ctl.acc_clear)
            begin
                acc_reg <= '0;
            end
            else if (b_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign busy   = a_valid_reg | b_valid_reg;
    assign result = acc_reg[OUT_POS +: OUT_W];

endmodule

FILE: hdl/fir_filter_power_of_two_coefficients.sv
// fir filter with signed power-of-two coefficients, shift-and-add form
// input stream: tuser selects the item kind (load group size, load coefficient
// word, filter one sample); tdata carries table index, table word and sample.
// load items are accepted back to back while idle and produce no output beat.
// a sample beat is written into the 256-deep history, then one shared 64-bit
// add/subtract unit walks the coefficients: one coefficient or one empty group
// per cycle through a three-stage pipe (coefficient ram, history ram, adder).
// tvalid rises once the walk has drained and the result is registered; the walk
// issues one op per coefficient covered by the groups plus one per empty
// group, at most 527 ops; tready stays low from a sample's acceptance until
// its result is registered, so no new item is accepted during the walk.
// the output register holds the 40-bit result until taken; the next item is
// accepted while it waits, and a new sample stalls at its end if the last
// result has still not been taken.
// reset clears the group table, the history valid flags and the history pointer at once;
// coefficient words must be loaded before a sample uses them.
module fir_filter_power_of_two_coefficients
    import fir_p2c_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // table_index, table_word, sample, zero pad
    input  logic [MODE_W-1:0]     s_axis_tuser,  // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata   // filtered
);

    `include "fir_filter_power_of_two_coefficients_assert.svh"

    state_t                    state_reg;
    state_t                    state_next;
    logic [SIZE_W-1:0]         group_size_reg [NUM_GROUPS];
    logic [GROUP_AW-1:0]       g_reg;
    logic [GROUP_AW-1:0]       g_next;
    logic [CCNT_W-1:0]         i_reg;
    logic [CCNT_W-1:0]         i_next;
    logic [CCNT_W-1:0]         grp_end_reg;
    logic [CCNT_W-1:0]         grp_end_next;
    logic                      out_valid_reg;
    logic [OUT_W-1:0]          out_data_reg;

    mode_t                     in_mode;
    logic [INDEX_W-1:0]        table_index;
    logic [SIZE_W-1:0]         table_word;
    logic signed [SAMPLE_W-1:0] sample;
    logic                      in_accept;
    logic                      start;
    logic                      grp_done;
    logic                      finish;
    issue_t                    issue;
    dp_ctl_t                   dp_ctl;
    logic                      dp_busy;
    logic [OUT_W-1:0]          dp_result;

    assign in_mode     = mode_t'(s_axis_tuser);
    assign table_index = s_axis_tdata[INDEX_W-1:0];
    assign table_word  = s_axis_tdata[INDEX_W +: SIZE_W];
    assign sample      = s_axis_tdata[INDEX_W + SIZE_W +: SAMPLE_W];

    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign start     = in_accept && (in_mode == MODE_FILTER);
    assign finish    = (state_reg == ST_FINISH) && !dp_busy
                       && (!out_valid_reg || m_axis_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (grp_done && (g_reg == GROUP_AW'(NUM_GROUPS - 1)))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        issue         = '0;
        grp_done      = 1'b0;
        issue.addr    = i_reg[COEF_AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_RUN:
            begin
                issue.valid = 1'b1;
                if (i_reg < grp_end_reg)
                begin
                    issue.term = 1'b1;
                    issue.last = ((i_reg + 1'b1) == grp_end_reg);
                end
                else
                begin
                    // empty group still shifts the accumulator
                    issue.last = 1'b1;
                end
                grp_done = issue.last;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        g_next       = g_reg;
        i_next       = i_reg;
        grp_end_next = grp_end_reg;
        if (start)
        begin
            g_next       = '0;
            i_next       = '0;
            grp_end_next = clamp_end('0, group_size_reg[0]);
        end
        else if (state_reg == ST_RUN)
        begin
            if (issue.term)
            begin
                i_next = i_reg + 1'b1;
            end
            if (grp_done)
            begin
                g_next       = g_reg + 1'b1;
                grp_end_next = clamp_end(grp_end_reg, group_size_reg[g_reg + 1'b1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            g_reg         <= '0;
            i_reg         <= '0;
            grp_end_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_GROUPS; k++)
            begin
                group_size_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            g_reg       <= g_next;
            i_reg       <= i_next;
            grp_end_reg <= grp_end_next;
            if (in_accept && (in_mode == MODE_LOAD_GROUP)
                && ((INDEX_W + 1)'(table_index) < (INDEX_W + 1)'(NUM_GROUPS)))
            begin
                group_size_reg[table_index[GROUP_AW-1:0]] <= table_word;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= dp_result;
        end
    end

    always_comb
    begin
        dp_ctl.acc_clear   = start;
        dp_ctl.hist_we     = start;
        dp_ctl.ptr_advance = finish;
        dp_ctl.coef_we     = in_accept && (in_mode == MODE_LOAD_COEF)
                             && ((INDEX_W + 1)'(table_index) < (INDEX_W + 1)'(NUM_COEFFS));
    end

    fir_p2c_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (dp_ctl),
        .wr_addr (table_index[COEF_AW-1:0]),
        .wr_coef (table_word[COEF_W-1:0]),
        .sample  (sample),
        .issue   (issue),
        .busy    (dp_busy),
        .result  (dp_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `FIR_P2C_ASSERT_NEXT(a_filter_starts_run, start, state_reg == ST_RUN,
        "sample accept did not start the coefficient walk")
    `FIR_P2C_ASSERT_IMPLY(a_walk_bounded, state_reg == ST_RUN,
        (i_reg <= grp_end_reg) && (grp_end_reg <= CCNT_W'(NUM_COEFFS)),
        "coefficient index ran past the group end")
    `FIR_P2C_ASSERT_IMPLY(a_idle_pipe_empty, state_reg == ST_IDLE, !dp_busy,
        "datapath still busy while idle")
    `FIR_P2C_ASSERT_IMPLY(a_result_from_finish, $rose(m_axis_tvalid),
        $past(state_reg == ST_FINISH), "output beat raised outside finish")

endmodule
